// File: hw/rtl/rf3_pkg.sv
// rf3_pkg: shared types, constants and helpers for the 3x3 rank filter.
// Used by every module of the rank_filter_3x3 block; depends on nothing else.

package rf3_pkg;

    // Geometry and field widths
    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int WIN_N       = 9;
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int ROW_W       = FH_W + 1;
    localparam int PEND_W      = FW_W;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Output queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANK_MODE    = 2'd2;

    // Register reset values
    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 16'd480;

    // Rank modes
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

    // Item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;
    localparam int SUM_W      = PIX_W + 2;
    localparam int PROD_W     = 2 * SUM_W;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] window_t;

    typedef struct packed {
        pix_t newer;
        pix_t older;
    } line_t;

    typedef struct packed {
        pix_t value;
        logic last;
    } result_t;

    typedef struct packed {
        logic valid;
        logic have;
        logic interior;
        logic last;
    } stage_ctl_t;

    function automatic pix_t gray_of(input pix_t r, input pix_t g, input pix_t b);
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;
        sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
        prod = PROD_W'(sum) * PROD_W'(GRAY_RECIP);
        return prod[GRAY_SHIFT +: PIX_W];
    endfunction

endpackage

// File: hw/rtl/rf3_line_store.sv
// rf3_line_store: row memory holding the gray values of the two rows above.
// One write and one read port, registered read data; uses rf3_pkg.

module rf3_line_store (
    input  logic                       clk,
    input  logic [rf3_pkg::ADDR_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [rf3_pkg::ADDR_W-1:0] wr_addr,
    input  rf3_pkg::line_t             wr_data,
    output rf3_pkg::line_t             rd_data
);
    import rf3_pkg::*;

    line_t mem_reg [MAX_WIDTH];
    line_t rd_data_reg;

    // Read before write on a shared address
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rf3_rank.sv
// rf3_rank: minimum, median or maximum of a 3x3 window, or its center on the border.
// Pure combinational; uses rf3_pkg.

module rf3_rank (
    input  rf3_pkg::window_t           window,
    input  logic [rf3_pkg::MODE_W-1:0] mode,
    input  logic                       interior,
    output rf3_pkg::pix_t              value
);
    import rf3_pkg::*;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    pix_t row_lo  [3];
    pix_t row_mid [3];
    pix_t row_hi  [3];
    pix_t win_min;
    pix_t win_max;
    pix_t win_med;

    // Sort each window row
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_lo[k]  = min2(window[k*3], min2(window[k*3+1], window[k*3+2]));
            row_hi[k]  = max2(window[k*3], max2(window[k*3+1], window[k*3+2]));
            row_mid[k] = med3(window[k*3], window[k*3+1], window[k*3+2]);
        end
    end

    // Combine rows: extremes directly, median from the three middle candidates
    assign win_min = min2(row_lo[0], min2(row_lo[1], row_lo[2]));
    assign win_max = max2(row_hi[0], max2(row_hi[1], row_hi[2]));
    assign win_med = med3(max2(row_lo[0], max2(row_lo[1], row_lo[2])),
                          med3(row_mid[0], row_mid[1], row_mid[2]),
                          min2(row_hi[0], min2(row_hi[1], row_hi[2])));

    // Select the center on the border, else by mode; the unused code acts as median
    always_comb
    begin
        if (!interior)
        begin
            value = window[4];
        end
        else
        begin
            case (mode)
                MODE_MIN: value = win_min;
                MODE_MAX: value = win_max;
                default:  value = win_med;
            endcase
        end
    end

endmodule

// File: hw/rtl/rf3_out_fifo.sv
// rf3_out_fifo: small result queue that decouples the pipeline from the receiver.
// Uses rf3_pkg for the result type and depth.

module rf3_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  rf3_pkg::result_t               push_data,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output rf3_pkg::result_t               pop_data,
    output logic [rf3_pkg::FIFO_CNT_W-1:0] count
);
    import rf3_pkg::*;

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/rank_filter_3x3.sv
// rank_filter_3x3: top level of the streaming 3x3 rank filter.
// Depends on rf3_pkg, rf3_line_store, rf3_rank and rf3_out_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per pixel in raster order
//   (kind = pixel, red/green/blue) or a drain beat (kind = drain). After the last
//   pixel of a frame, send frame_width+1 drain beats to flush the remaining results;
//   the final result carries last_of_frame.
//   Output channel (out_valid/out_ready) carries pixel_value and last_of_frame in
//   raster order, one row plus one pixel behind the input.
//   Throughput: one beat per clock while in_ready is high. A beat that yields a result
//   passes the accept, row memory read and rank stages and the result queue to the output.
//   The row memory is read and written once per beat; a write still in flight to the
//   address just read is forwarded.
//   Configuration: write cfg_index/cfg_data with cfg_we only while idle. Writing the
//   width or height restarts the frame; writing the mode does not.
//   Reset: width 640, height 480, median mode, positions and pipeline cleared. The row
//   memory is not cleared; no entry is used before the current frame writes it.
//   Stall: a 4-entry result queue absorbs receiver stalls; in_ready drops once four
//   beats are in the pipeline or queue, and recovers as results are taken.

module rank_filter_3x3 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  rf3_pkg::pix_t                  red,
    input  rf3_pkg::pix_t                  green,
    input  rf3_pkg::pix_t                  blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rf3_pkg::pix_t                  pixel_value,
    output logic                           last_of_frame,
    input  logic                           cfg_we,
    input  logic [rf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rf3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rf3_pkg::*;

    // Configuration
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic              geom_write;

    // Position tracking
    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    // Entry stage
    logic              accept;
    logic              step;
    logic              have0;
    logic              interior0;
    logic              last0;
    logic [FW_W-1:0]   col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              wrap;
    pix_t              gray0;
    logic              fwd0;

    // Memory read stage
    stage_ctl_t        s1_ctl_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    pix_t              s1_gray_reg;
    logic              s1_fwd_reg;
    line_t             s1_fwd_line_reg;
    line_t             rd_line;
    line_t             line1;
    line_t             wr_line;

    // Rank stage
    window_t           window_reg;
    stage_ctl_t        s2_ctl_reg;
    pix_t              rank_value;
    result_t           push_data;
    result_t           pop_data;
    logic              push;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] occupancy;

    // Effective geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (width_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? FH_W'(1) : height_reg;
    end

    assign geom_write = cfg_we &&
                        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            mode_reg   <= MODE_MED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                REG_RANK_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input credit: beats in flight plus queued results
    assign occupancy = fifo_count + FIFO_CNT_W'(s1_ctl_reg.valid) + FIFO_CNT_W'(s2_ctl_reg.valid);
    assign in_ready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept    = in_valid && in_ready;

    // Drop pixels while draining and drains with nothing owed
    assign step = accept && ((kind == KIND_PIXEL) ? (pend_reg == '0) : (pend_reg != '0));

    // Result position and border test
    assign have0     = (col_reg == '0) ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
    assign interior0 = (col_reg >= ADDR_W'(2)) && (row_reg >= ROW_W'(2)) &&
                       (row_reg < ROW_W'(h_eff));
    assign col_inc   = FW_W'(col_reg) + FW_W'(1);
    assign row_inc   = row_reg + ROW_W'(1);
    assign wrap      = (col_inc == w_eff);
    assign gray0     = (kind == KIND_PIXEL) ? gray_of(red, green, blue) : '0;

    // Advance position and drain count
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        last0     = 1'b0;
        if (geom_write)
        begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end
        else if (step)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = row_inc;
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
            end
            if (kind == KIND_PIXEL)
            begin
                if (wrap && (row_inc >= ROW_W'(h_eff)))
                begin
                    pend_next = w_eff + PEND_W'(1);
                end
            end
            else
            begin
                pend_next = pend_reg - PEND_W'(1);
                if (pend_reg == PEND_W'(1))
                begin
                    last0    = 1'b1;
                    col_next = '0;
                    row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    // Row memory: read at the current column, write back in the next cycle
    rf3_line_store u_line_store (
        .clk     (clk),
        .rd_addr (col_reg),
        .wr_en   (s1_ctl_reg.valid),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_line),
        .rd_data (rd_line)
    );

    // Forward the write in flight when the next beat reads the same column
    assign fwd0          = s1_ctl_reg.valid && (s1_addr_reg == col_reg);
    assign line1         = s1_fwd_reg ? s1_fwd_line_reg : rd_line;
    assign wr_line.newer = s1_gray_reg;
    assign wr_line.older = line1.newer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg.valid    <= step;
            s1_ctl_reg.have     <= have0;
            s1_ctl_reg.interior <= interior0;
            s1_ctl_reg.last     <= last0;
            s2_ctl_reg          <= s1_ctl_reg;
        end
    end

    // Hold the beat payload for the memory stage
    always_ff @(posedge clk)
    begin
        s1_addr_reg     <= col_reg;
        s1_gray_reg     <= gray0;
        s1_fwd_reg      <= fwd0;
        s1_fwd_line_reg <= wr_line;
    end

    // Shift the window left and load the new column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_ctl_reg.valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_reg[k*3]   <= window_reg[k*3+1];
                window_reg[k*3+1] <= window_reg[k*3+2];
            end
            window_reg[2] <= line1.older;
            window_reg[5] <= line1.newer;
            window_reg[8] <= s1_gray_reg;
        end
    end

    rf3_rank u_rank (
        .window   (window_reg),
        .mode     (mode_reg),
        .interior (s2_ctl_reg.interior),
        .value    (rank_value)
    );

    assign push            = s2_ctl_reg.valid && s2_ctl_reg.have;
    assign push_data.value = rank_value;
    assign push_data.last  = s2_ctl_reg.last;

    rf3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign pixel_value   = pop_data.value;
    assign last_of_frame = pop_data.last;

endmodule

// File: hw/rtl/rf3_checker.sv
// rf3_checker: port-level checks for rank_filter_3x3, attached by bind.
// Uses rf3_pkg for port types.

module rf3_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           kind,
    input  rf3_pkg::pix_t                  red,
    input  rf3_pkg::pix_t                  green,
    input  rf3_pkg::pix_t                  blue,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  rf3_pkg::pix_t                  pixel_value,
    input  logic                           last_of_frame,
    input  logic                           cfg_we,
    input  logic [rf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rf3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rf3_pkg::*;

    // Output queue is empty right after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(last_of_frame))
        else $error("stalled result changed");

    // Input back-pressure only while results wait on the output
    a_ready_credit: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // A result appearing on an empty output comes from an accepted beat passed through the memory and rank stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result without matching input beat");

endmodule

bind rank_filter_3x3 rf3_checker u_rf3_checker (.*);
